// ----- sv/lzobp_pkg.sv -----
// ----------------------------------------------------------------------------
// lzobp_pkg
// Shared constants and types of the LZ output bit packer: item kinds, store
// geometry, the result record and the store access request.
// ----------------------------------------------------------------------------
`default_nettype none

package lzobp_pkg;

    localparam int LP_BUF_DEPTH = 65536;
    localparam int LP_ADDR_W    = $clog2(LP_BUF_DEPTH);
    localparam int LP_MAX_COPY  = 64;

    localparam logic [16:0] LP_POS_DEPTH = 17'(LP_BUF_DEPTH);
    localparam logic [6:0]  LP_COPY_MAX  = 7'(LP_MAX_COPY);

    localparam logic [2:0] KIND_BITS   = 3'd0;
    localparam logic [2:0] KIND_GAMMA  = 3'd1;
    localparam logic [2:0] KIND_BYTE   = 3'd2;
    localparam logic [2:0] KIND_WORD   = 3'd3;
    localparam logic [2:0] KIND_COPY   = 3'd4;
    localparam logic [2:0] KIND_FLUSH  = 3'd5;
    localparam logic [2:0] KIND_SETPOS = 3'd6;

    typedef struct packed {
        logic        written;
        logic [15:0] addr;
        logic [7:0]  value;
        logic [16:0] pos;
        logic        ovf;
        logic        last;
    } t_result;

    typedef struct packed {
        logic                 we;
        logic [LP_ADDR_W-1:0] waddr;
        logic [7:0]           wdata;
        logic                 re;
        logic [LP_ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// ----- sv/lzobp_ram.sv -----
// ----------------------------------------------------------------------------
// lzobp_ram
// Simple dual-port synchronous RAM, one write and one read port, read data
// registered and held while no read is requested.
// ----------------------------------------------------------------------------
`default_nettype none

module lzobp_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/lzobp_out_reg.sv -----
// ----------------------------------------------------------------------------
// lzobp_out_reg
// Output register of the result channel. Holds one result until its transfer
// and tells the sequencer when a new result may be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module lzobp_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire lzobp_pkg::t_result i_result,
    output logic                    o_free,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output lzobp_pkg::t_result      o_result
);

    import lzobp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lzobp_seq.sv -----
// ----------------------------------------------------------------------------
// lzobp_seq
// Item sequencer: bit accumulator, write position and the writes to the
// byte store for bit groups, bytes, words, copies and flushes, with copy reads.
// ----------------------------------------------------------------------------
`default_nettype none

module lzobp_seq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [2:0]          i_kind,
    input  wire logic [4:0]          i_bit_count,
    input  wire logic [15:0]         i_bit_value,
    input  wire logic [5:0]          i_gamma_zeros,
    input  wire logic [15:0]         i_data_value,
    input  wire logic [15:0]         i_copy_source,
    input  wire logic [6:0]          i_copy_length,
    input  wire logic [15:0]         i_new_position,
    input  wire logic                i_out_free,
    output logic                     o_emit,
    output lzobp_pkg::t_result       o_result,
    output lzobp_pkg::t_mem_req      o_mem,
    input  wire logic [7:0]          i_mem_rdata
);

    import lzobp_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_BITS    = 3'd1;
    localparam logic [2:0] ST_BYTE    = 3'd2;
    localparam logic [2:0] ST_FLUSH   = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_COPY_RD = 3'd5;
    localparam logic [2:0] ST_COPY_WR = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [16:0] r_pos,   n_pos;
    logic [8:0]  r_acc,   n_acc;
    logic [2:0]  r_fill,  n_fill;
    logic [15:0] r_bits,  n_bits;
    logic [6:0]  r_nbits, n_nbits;
    logic        r_any,   n_any;
    logic [15:0] r_data,  n_data;
    logic        r_word,  n_word;
    logic [16:0] r_src,   n_src;
    logic [6:0]  r_cnt,   n_cnt;
    logic        r_zero,  n_zero;

    // bit group step
    logic [3:0]  room;
    logic [3:0]  take;
    logic [8:0]  packed_acc;
    logic        acc_full;
    logic [6:0]  rest;

    // result request
    logic        emit_req;
    logic        emit_byte;
    logic [7:0]  emit_val;
    logic        emit_last;
    logic        grant;
    logic        in_room;
    logic [16:0] pos_after;

    assign o_in_ready = (r_state == ST_IDLE);
    assign grant      = emit_req && i_out_free;
    assign o_emit     = grant;
    assign in_room    = (r_pos < LP_POS_DEPTH);

    always_comb begin
        logic [8:0] tmp;
        room = 4'd8 - {1'b0, r_fill};
        take = (r_nbits < {3'b000, room}) ? r_nbits[3:0] : room;
        tmp  = r_acc;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < take) begin
                tmp = {tmp[7:0], r_bits[i]};
            end
        end
        packed_acc = tmp;
        acc_full   = tmp[8];
        rest       = r_nbits - {3'b000, take};
    end

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_fill    = r_fill;
        n_bits    = r_bits;
        n_nbits   = r_nbits;
        n_any     = r_any;
        n_data    = r_data;
        n_word    = r_word;
        n_src     = r_src;
        n_cnt     = r_cnt;
        n_zero    = r_zero;
        emit_req  = 1'b0;
        emit_byte = 1'b0;
        emit_val  = 8'd0;
        emit_last = 1'b1;
        o_mem     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_BITS: begin
                            n_bits  = i_bit_value;
                            n_nbits = {2'b00, i_bit_count};
                            n_any   = 1'b0;
                            n_state = ST_BITS;
                        end
                        KIND_GAMMA: begin
                            n_bits  = 16'd1;
                            n_nbits = {1'b0, i_gamma_zeros} + 7'd1;
                            n_any   = 1'b0;
                            n_state = ST_BITS;
                        end
                        KIND_BYTE: begin
                            n_data  = i_data_value;
                            n_word  = 1'b0;
                            n_state = ST_BYTE;
                        end
                        KIND_WORD: begin
                            n_data  = i_data_value;
                            n_word  = 1'b1;
                            n_state = ST_BYTE;
                        end
                        KIND_COPY: begin
                            n_cnt   = (i_copy_length > LP_COPY_MAX) ? LP_COPY_MAX
                                                                    : i_copy_length;
                            n_src   = {1'b0, i_copy_source};
                            n_state = (i_copy_length == 7'd0) ? ST_EMPTY : ST_COPY_RD;
                        end
                        KIND_FLUSH: begin
                            n_state = ST_FLUSH;
                        end
                        KIND_SETPOS: begin
                            n_pos   = ({1'b0, i_new_position} > LP_POS_DEPTH)
                                      ? LP_POS_DEPTH : {1'b0, i_new_position};
                            n_state = ST_EMPTY;
                        end
                        default: begin
                            n_state = ST_EMPTY;
                        end
                    endcase
                end
            end
            ST_BITS: begin
                if (r_nbits == 7'd0) begin
                    if (r_any) begin
                        n_state = ST_IDLE;
                    end else begin
                        emit_req = 1'b1;
                        if (grant) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else if (!acc_full) begin
                    n_acc   = packed_acc;
                    n_fill  = r_fill + take[2:0];
                    n_bits  = r_bits >> take;
                    n_nbits = rest;
                end else begin
                    emit_req  = 1'b1;
                    emit_byte = 1'b1;
                    emit_val  = packed_acc[7:0];
                    emit_last = (rest < 7'd8);
                    if (grant) begin
                        n_acc   = 9'd1;
                        n_fill  = 3'd0;
                        n_bits  = r_bits >> take;
                        n_nbits = rest;
                        n_any   = 1'b1;
                        if (rest == 7'd0) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_BYTE: begin
                emit_req  = 1'b1;
                emit_byte = 1'b1;
                emit_val  = r_data[7:0];
                emit_last = !r_word;
                if (grant) begin
                    if (r_word) begin
                        n_data = {8'd0, r_data[15:8]};
                        n_word = 1'b0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                emit_req  = 1'b1;
                emit_byte = 1'b1;
                emit_val  = r_acc[7:0];
                if (grant) begin
                    n_acc   = 9'd1;
                    n_fill  = 3'd0;
                    n_state = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                emit_req = 1'b1;
                if (grant) begin
                    n_state = ST_IDLE;
                end
            end
            ST_COPY_RD: begin
                // the previous copy byte was written at the last edge, so the
                // read here already sees it
                o_mem.re    = 1'b1;
                o_mem.raddr = r_src[LP_ADDR_W-1:0];
                n_zero      = (r_src >= LP_POS_DEPTH);
                n_state     = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                emit_req  = 1'b1;
                emit_byte = 1'b1;
                emit_val  = r_zero ? 8'd0 : i_mem_rdata;
                emit_last = (r_cnt == 7'd1);
                if (grant) begin
                    n_cnt   = r_cnt - 7'd1;
                    n_src   = r_src + 17'd1;
                    n_state = (r_cnt == 7'd1) ? ST_IDLE : ST_COPY_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        pos_after = in_room ? (r_pos + 17'd1) : LP_POS_DEPTH;

        o_result = '0;
        o_result.last = emit_last;
        o_result.pos  = r_pos;
        if (emit_byte) begin
            o_result.written = in_room;
            o_result.ovf     = !in_room;
            o_result.addr    = r_pos[15:0];
            o_result.value   = emit_val;
            o_result.pos     = pos_after;
            if (grant) begin
                n_pos       = pos_after;
                o_mem.we    = in_room;
                o_mem.waddr = r_pos[LP_ADDR_W-1:0];
                o_mem.wdata = emit_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= 17'd0;
            r_acc   <= 9'd1;
            r_fill  <= 3'd0;
            r_any   <= 1'b0;
            r_word  <= 1'b0;
            r_cnt   <= 7'd0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_fill  <= n_fill;
            r_any   <= n_any;
            r_word  <= n_word;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits  <= n_bits;
        r_nbits <= n_nbits;
        r_data  <= n_data;
        r_src   <= n_src;
        r_zero  <= n_zero;
    end

endmodule

`default_nettype wire

// ----- sv/lz_output_bit_packer.sv -----
// ----------------------------------------------------------------------------
// lz_output_bit_packer
// Output stage of an LZ compressor: sentinel bit accumulator, byte store and
// write position, one result per byte that goes out or per item with none.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A byte, flush, set-position or empty item
// gives one result, a word two, and a bit or gamma item is packed in groups
// of up to eight bits that fill or end the accumulator, with one result per
// full byte or one empty result if no byte fills. A copy handles each byte as
// a store read with registered read data, then the write back and result,
// which also orders overlapping copies correctly. Every result waits for a
// free output register, so a stalled result channel holds the item back.
// The store has no clearing pass; copying a never written entry returns
// whatever the RAM holds.
`default_nettype none

module lz_output_bit_packer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [4:0]  i_bit_count,
    input  wire logic [15:0] i_bit_value,
    input  wire logic [5:0]  i_gamma_zeros,
    input  wire logic [15:0] i_data_value,
    input  wire logic [15:0] i_copy_source,
    input  wire logic [6:0]  i_copy_length,
    input  wire logic [15:0] i_new_position,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_byte_written,
    output logic [15:0]      o_byte_address,
    output logic [7:0]       o_byte_value,
    output logic [16:0]      o_position_after,
    output logic             o_overflow,
    output logic             o_last
);

    import lzobp_pkg::*;

    t_result  seq_result;
    t_result  out_result;
    t_mem_req mem_req;
    logic     emit;
    logic     out_free;
    logic [7:0] mem_rdata;

    lzobp_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_bit_count    (i_bit_count),
        .i_bit_value    (i_bit_value),
        .i_gamma_zeros  (i_gamma_zeros),
        .i_data_value   (i_data_value),
        .i_copy_source  (i_copy_source),
        .i_copy_length  (i_copy_length),
        .i_new_position (i_new_position),
        .i_out_free     (out_free),
        .o_emit         (emit),
        .o_result       (seq_result),
        .o_mem          (mem_req),
        .i_mem_rdata    (mem_rdata)
    );

    lzobp_ram #(
        .ADDR_W (LP_ADDR_W),
        .DATA_W (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    lzobp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (seq_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_byte_written   = out_result.written;
    assign o_byte_address   = out_result.addr;
    assign o_byte_value     = out_result.value;
    assign o_position_after = out_result.pos;
    assign o_overflow       = out_result.ovf;
    assign o_last           = out_result.last;

endmodule

`default_nettype wire

// ----- sv/lzobp_checker.sv -----
// ----------------------------------------------------------------------------
// lzobp_checker
// Port-level checks of the LZ output bit packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lzobp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_byte_written,
    input wire logic [15:0] o_byte_address,
    input wire logic [7:0]  o_byte_value,
    input wire logic [16:0] o_position_after,
    input wire logic        o_overflow
);

    import lzobp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_byte_value) && $stable(o_position_after))
        else $error("result changed while stalled");

    // one item at a time
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in work");

    a_wr_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_byte_written && o_overflow))
        else $error("byte both stored and dropped");

    a_wr_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_written |->
            o_position_after == ({1'b0, o_byte_address} + 17'd1))
        else $error("position does not follow stored byte");

    a_ovf_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_position_after == LP_POS_DEPTH)
        else $error("dropped byte with position below store end");

endmodule

bind lz_output_bit_packer lzobp_checker u_lzobp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_byte_written   (o_byte_written),
    .o_byte_address   (o_byte_address),
    .o_byte_value     (o_byte_value),
    .o_position_after (o_position_after),
    .o_overflow       (o_overflow)
);

`default_nettype wire
